// ----- src/mpcs_pkg.sv -----
package mpcs_pkg;

	localparam int ADC_BITS  = 12;
	localparam int NPHASES   = 3;
	localparam int NLANES    = 4;
	localparam int HALL_W    = 3;
	localparam int GAIN_W    = 16;
	localparam int COEF_W    = 16;
	localparam int GAIN_FRAC = 12;

	localparam int XPROD_W   = ADC_BITS + GAIN_W;
	localparam int BSUM_W    = ADC_BITS + 1;
	localparam int BPROD_W   = BSUM_W + GAIN_W;
	localparam int RAW_BUS_W = BPROD_W - GAIN_FRAC;
	localparam int Y_W       = RAW_BUS_W + GAIN_FRAC;
	localparam int DIFF_W    = Y_W + 1;
	localparam int FPROD_W   = COEF_W + 1 + DIFF_W;

	localparam int OUT_W     = 20;
	localparam int OUT_SHIFT = 8;

	localparam int TD_HALL_LSB = NPHASES * ADC_BITS;
	localparam int TD_CLR_BIT  = TD_HALL_LSB + HALL_W;
	localparam int S_TDATA_W   = 40;
	localparam int M_PAYLOAD_W = NLANES * OUT_W + NPHASES * ADC_BITS;
	localparam int M_TDATA_W   = 120;

	localparam int REG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [REG_IDX_W-1:0] REG_CURRENT_GAIN = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_FILTER_COEF  = 1'd1;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd27499;
	localparam logic [COEF_W-1:0] COEF_RESET = 16'd6554;

	localparam logic OP_CALIBRATE = 1'b0;
	localparam logic OP_MEASURE   = 1'b1;

	localparam logic [HALL_W-1:0] HALL_VW_LO = 3'd3;
	localparam logic [HALL_W-1:0] HALL_VW_HI = 3'd4;
	localparam logic [HALL_W-1:0] HALL_UV_LO = 3'd1;
	localparam logic [HALL_W-1:0] HALL_UV_HI = 3'd6;
	localparam logic [HALL_W-1:0] HALL_UW_LO = 3'd2;
	localparam logic [HALL_W-1:0] HALL_UW_HI = 3'd5;

	typedef enum logic [9:0] {
		ST_IDLE       = 10'b00_0000_0001,
		ST_START      = 10'b00_0000_0010,
		ST_CAL_ACC    = 10'b00_0000_0100,
		ST_CAL_DIV    = 10'b00_0000_1000,
		ST_CAL_OFS    = 10'b00_0001_0000,
		ST_MEAS_SCALE = 10'b00_0010_0000,
		ST_MEAS_BUS   = 10'b00_0100_0000,
		ST_MEAS_FILT  = 10'b00_1000_0000,
		ST_MEAS_UPD   = 10'b01_0000_0000,
		ST_OUT        = 10'b10_0000_0000
	} state_t;

	typedef struct packed {
		logic load_in;
		logic start;
		logic cal_acc;
		logic cal_div;
		logic cal_ofs;
		logic meas_scale;
		logic meas_bus;
		logic meas_filt;
		logic meas_upd;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic op;
	} sts_t;

endpackage

// ----- src/mpcs_ctrl.sv -----
module mpcs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	input  mpcs_pkg::sts_t sts,
	output mpcs_pkg::cmd_t cmd
);
	import mpcs_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.load_in = s_tvalid && s_tready;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_START;
			end
			ST_START: begin
				cmd.start = 1'b1;
				state_d   = (sts.op == OP_MEASURE) ? ST_MEAS_SCALE : ST_CAL_ACC;
			end
			ST_CAL_ACC: begin
				cmd.cal_acc = 1'b1;
				state_d     = ST_CAL_DIV;
			end
			ST_CAL_DIV: begin
				cmd.cal_div = 1'b1;
				state_d     = ST_CAL_OFS;
			end
			ST_CAL_OFS: begin
				cmd.cal_ofs = 1'b1;
				state_d     = ST_OUT;
			end
			ST_MEAS_SCALE: begin
				cmd.meas_scale = 1'b1;
				state_d        = ST_MEAS_BUS;
			end
			ST_MEAS_BUS: begin
				cmd.meas_bus = 1'b1;
				state_d      = ST_MEAS_FILT;
			end
			ST_MEAS_FILT: begin
				cmd.meas_filt = 1'b1;
				state_d       = ST_MEAS_UPD;
			end
			ST_MEAS_UPD: begin
				cmd.meas_upd = 1'b1;
				state_d      = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || m_tready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item accepted while sequencer busy");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!m_tvalid || m_tready))
		else $error("output register overwritten before taken");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> m_tvalid)
		else $error("result loaded but not presented");

endmodule

// ----- src/mpcs_dp.sv -----
module mpcs_dp #(
	parameter int HISTORY_DEPTH = 50
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [mpcs_pkg::S_TDATA_W-1:0]     s_tdata,
	input  logic                               s_tuser,
	output logic [mpcs_pkg::M_TDATA_W-1:0]     m_tdata,
	input  logic                               cfg_we,
	input  logic [mpcs_pkg::REG_IDX_W-1:0]     cfg_addr,
	input  logic [mpcs_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  mpcs_pkg::cmd_t                     cmd,
	output mpcs_pkg::sts_t                     sts
);
	import mpcs_pkg::*;

	localparam int SUM_W   = ADC_BITS + $clog2(HISTORY_DEPTH + 1);
	localparam int PTR_W   = $clog2(HISTORY_DEPTH);
	localparam int SHIFT   = SUM_W + $clog2(HISTORY_DEPTH);
	localparam int RECIP_W = SUM_W + 1;
	localparam int QP_W    = SUM_W + RECIP_W;
	localparam int ROW_W   = NPHASES * ADC_BITS;
	// ceil(2^SHIFT / depth): exact floor quotient for every sum below 2^SUM_W
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << SHIFT) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH));
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HISTORY_DEPTH - 1);
	localparam logic signed [FPROD_W-1:0] ROUND_HALF = FPROD_W'(1) << (COEF_W - 1);

	logic [GAIN_W-1:0] gain_q;
	logic [COEF_W-1:0] coef_q;

	logic                              op_q;
	logic                              clr_q;
	logic [HALL_W-1:0]                 hall_q;
	logic [NPHASES-1:0][ADC_BITS-1:0]  raw_q;

	logic [ROW_W-1:0] hist_mem [HISTORY_DEPTH];
	logic [ROW_W-1:0] rd_q;
	logic [PTR_W-1:0] ptr_q;
	logic             full_q;

	logic [NPHASES-1:0][SUM_W-1:0]     sum_q;
	logic [NPHASES-1:0][QP_W-1:0]      qprod_q;
	logic [NPHASES-1:0][ADC_BITS-1:0]  off_q;
	logic [NPHASES-1:0][ADC_BITS-1:0]  held_q;

	logic [NPHASES-1:0][XPROD_W-1:0]   xprod_q;
	logic [BPROD_W-1:0]                bprod_q;
	logic                              bus_ok_q;
	logic [RAW_BUS_W-1:0]              raw_bus_q;
	logic signed [FPROD_W-1:0]         fprod_q [NLANES];
	logic [NLANES-1:0][Y_W-1:0]        y_q;

	logic [NLANES-1:0][OUT_W-1:0]      cur_out_q;
	logic [NPHASES-1:0][ADC_BITS-1:0]  off_out_q;

	logic [BSUM_W-1:0]                 bsum_c;
	logic                              bus_ok_c;
	logic [Y_W-1:0]                    x_c    [NLANES];
	logic signed [DIFF_W-1:0]          diff_c [NLANES];
	logic signed [FPROD_W-1:0]         acc_c  [NLANES];

	assign sts.op  = op_q;
	assign m_tdata = {(M_TDATA_W - M_PAYLOAD_W)'(0), off_out_q, cur_out_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
			coef_q <= COEF_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_CURRENT_GAIN: gain_q <= cfg_data;
				REG_FILTER_COEF:  coef_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q   <= s_tuser;
			clr_q  <= s_tdata[TD_CLR_BIT];
			hall_q <= s_tdata[TD_HALL_LSB +: HALL_W];
			for (int i = 0; i < NPHASES; i++) raw_q[i] <= s_tdata[i*ADC_BITS +: ADC_BITS];
		end
	end

	// history rows; the row under the pointer holds data only once the ring has wrapped
	always_ff @(posedge clk) begin
		if (cmd.start) rd_q <= hist_mem[ptr_q];
		if (cmd.cal_acc) hist_mem[ptr_q] <= raw_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			full_q <= 1'b0;
			sum_q  <= '0;
			off_q  <= '0;
		end else begin
			if (cmd.cal_acc) begin
				for (int i = 0; i < NPHASES; i++) begin
					sum_q[i] <= sum_q[i]
						- (full_q ? SUM_W'(rd_q[i*ADC_BITS +: ADC_BITS]) : SUM_W'(0))
						+ SUM_W'(raw_q[i]);
				end
				if (ptr_q == PTR_LAST) begin
					ptr_q  <= '0;
					full_q <= 1'b1;
				end else begin
					ptr_q <= ptr_q + PTR_W'(1);
				end
			end
			if (cmd.cal_ofs) begin
				for (int i = 0; i < NPHASES; i++) off_q[i] <= qprod_q[i][SHIFT +: ADC_BITS];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cal_div) begin
			for (int i = 0; i < NPHASES; i++) qprod_q[i] <= QP_W'(sum_q[i]) * QP_W'(RECIP);
		end
	end

	always_comb begin
		bsum_c   = '0;
		bus_ok_c = 1'b1;
		case (hall_q) inside
			HALL_VW_LO, HALL_VW_HI: bsum_c = BSUM_W'(held_q[1]) + BSUM_W'(held_q[2]);
			HALL_UV_LO, HALL_UV_HI: bsum_c = BSUM_W'(held_q[0]) + BSUM_W'(held_q[1]);
			HALL_UW_LO, HALL_UW_HI: bsum_c = BSUM_W'(held_q[0]) + BSUM_W'(held_q[2]);
			default:                bus_ok_c = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.meas_scale) begin
			for (int i = 0; i < NPHASES; i++) xprod_q[i] <= XPROD_W'(held_q[i]) * XPROD_W'(gain_q);
			bprod_q  <= BPROD_W'(bsum_c) * BPROD_W'(gain_q);
			bus_ok_q <= bus_ok_c;
		end
	end

	// y' = y + a*(x - y)/2^16, rounded half up
	always_comb begin
		for (int i = 0; i < NPHASES; i++) x_c[i] = Y_W'(xprod_q[i]);
		x_c[NLANES-1] = {raw_bus_q, GAIN_FRAC'(0)};
		for (int i = 0; i < NLANES; i++) begin
			diff_c[i] = $signed({1'b0, x_c[i]}) - $signed({1'b0, y_q[i]});
			acc_c[i]  = $signed({2'b00, y_q[i], COEF_W'(0)}) + fprod_q[i] + ROUND_HALF;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.meas_filt) begin
			for (int i = 0; i < NLANES; i++) begin
				fprod_q[i] <= FPROD_W'($signed({1'b0, coef_q}) * diff_c[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q    <= '0;
			raw_bus_q <= '0;
			y_q       <= '0;
		end else begin
			if (cmd.start && op_q == OP_MEASURE) begin
				for (int i = 0; i < NPHASES; i++) begin
					if (raw_q[i] >= off_q[i]) held_q[i] <= raw_q[i] - off_q[i];
				end
			end
			if (cmd.meas_bus && bus_ok_q) raw_bus_q <= bprod_q[GAIN_FRAC +: RAW_BUS_W];
			if (cmd.meas_upd) begin
				for (int i = 0; i < NLANES; i++) begin
					y_q[i] <= clr_q ? Y_W'(0) : acc_c[i][COEF_W +: Y_W];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			for (int i = 0; i < NLANES; i++) begin
				cur_out_q[i] <= (|y_q[i][Y_W-1:OUT_SHIFT+OUT_W]) ? '1
					: y_q[i][OUT_SHIFT +: OUT_W];
			end
			off_out_q <= off_q;
		end
	end

	a_off_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.cal_ofs |=> $stable(off_q))
		else $error("offsets changed outside calibration");

	a_filt_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.meas_upd |=> $stable(y_q))
		else $error("filter state changed outside update step");

	a_bus_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.meas_bus && bus_ok_q) |=> $stable(raw_bus_q))
		else $error("raw bus current changed without valid hall state");

endmodule

// ----- src/motor_phase_current_sense_top.sv -----
// Sequence per item: a start state (history read), then for calibrate the running sum, reciprocal
// multiply and offset states, or for measure the scale, bus, filter and update states; then the
// output state loads the result register, stalling while the previous result has not been taken.
// A new item is taken while the previous result waits in the output register.
// Reset (arst_n low, async): filters, offsets, sums, pointer and config registers return to
// their reset values; the history ring reads as zero until it has wrapped once.
module motor_phase_current_sense_top #(
	parameter int HISTORY_DEPTH = 50
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// phase_u_raw, phase_v_raw, phase_w_raw, hall_state, clear_filters
	input  logic [mpcs_pkg::S_TDATA_W-1:0]  s_tdata,
	// operation
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// u_current, v_current, w_current, bus_current, u_offset, v_offset, w_offset, pad
	output logic [mpcs_pkg::M_TDATA_W-1:0]  m_tdata,
	input  logic                            cfg_we,
	input  logic [mpcs_pkg::REG_IDX_W-1:0]  cfg_addr,
	input  logic [mpcs_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mpcs_pkg::*;

	cmd_t cmd;
	sts_t sts;

	mpcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mpcs_dp #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

// ----- bench/motor_phase_current_sense_top_tb.sv -----
module motor_phase_current_sense_top_tb;
	import mpcs_pkg::*;

	localparam int HIST_DEPTH  = 50;
	localparam int CYCLE_LIMIT = 500000;
	localparam int ADC_MAX     = (1 << ADC_BITS) - 1;

	localparam logic [HALL_W-1:0] HALL_NONE_LO = 3'd0;
	localparam logic [HALL_W-1:0] HALL_NONE_HI = 3'd7;
	localparam logic [OUT_W-1:0]  AMPS_MAX     = '1;

	// u_current in the lowest bits, w_offset in the highest
	typedef struct packed {
		logic [ADC_BITS-1:0] w_offset;
		logic [ADC_BITS-1:0] v_offset;
		logic [ADC_BITS-1:0] u_offset;
		logic [OUT_W-1:0]    bus_current;
		logic [OUT_W-1:0]    w_current;
		logic [OUT_W-1:0]    v_current;
		logic [OUT_W-1:0]    u_current;
	} sense_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	// phase_u_raw, phase_v_raw, phase_w_raw, hall_state, clear_filters
	logic [S_TDATA_W-1:0]  s_tdata;
	// operation
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	// u_current, v_current, w_current, bus_current, u_offset, v_offset, w_offset, pad
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  cfg_we;
	logic [REG_IDX_W-1:0]  cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_data;

	motor_phase_current_sense_top #(.HISTORY_DEPTH(HIST_DEPTH)) uut (.*);

	// predictor state
	logic [GAIN_W-1:0]   gain_q412;
	logic [COEF_W-1:0]   lpf_coef;
	logic [ADC_BITS-1:0] cal_ring [NPHASES][HIST_DEPTH];
	logic [17:0]         cal_sum [NPHASES];
	logic [5:0]          cal_ptr;
	logic [ADC_BITS-1:0] zero_ofs [NPHASES];
	logic [ADC_BITS-1:0] held_cnt [NPHASES];
	logic [16:0]         bus_ma;
	logic [31:0]         lpf_y [NLANES];

	sense_t pending_sense[$];

	int  mismatch_count;
	int  results_seen;
	int  bus_sat_count;
	int  frames_sent;
	int  cal_frames;
	int  reg_writes;
	int  cycle_count;
	int  rx_hold_req;
	bit  tx_idle_on;
	bit  rx_idle_on;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic void reset_model();
		gain_q412 = GAIN_RESET;
		lpf_coef  = COEF_RESET;
		for (int i = 0; i < NPHASES; i++) begin
			for (int j = 0; j < HIST_DEPTH; j++)
				cal_ring[i][j] = '0;
			cal_sum[i]  = '0;
			zero_ofs[i] = '0;
			held_cnt[i] = '0;
		end
		cal_ptr = '0;
		bus_ma  = '0;
		for (int i = 0; i < NLANES; i++)
			lpf_y[i] = '0;
	endfunction

	function automatic logic [31:0] lpf_next(input logic [31:0] y, input logic [31:0] x);
		logic [63:0] acc;
		acc = (64'd65536 - 64'(lpf_coef)) * 64'(y) + 64'(lpf_coef) * 64'(x) + 64'd32768;
		return acc[47:16];
	endfunction

	function automatic logic [OUT_W-1:0] amps_of(input logic [31:0] y);
		logic [31:0] v;
		v = y >> OUT_SHIFT;
		return (v > 32'(AMPS_MAX)) ? AMPS_MAX : v[OUT_W-1:0];
	endfunction

	function automatic sense_t predict_sense(input logic op, input logic [ADC_BITS-1:0] u,
			input logic [ADC_BITS-1:0] v, input logic [ADC_BITS-1:0] w,
			input logic [HALL_W-1:0] hall, input logic clr);
		logic [ADC_BITS-1:0] raw [NPHASES];
		logic [BSUM_W-1:0]   pair;
		logic                pair_ok;
		sense_t              r;
		raw[0] = u;
		raw[1] = v;
		raw[2] = w;
		if (op == OP_CALIBRATE) begin
			for (int i = 0; i < NPHASES; i++) begin
				cal_sum[i] = cal_sum[i] - 18'(cal_ring[i][cal_ptr]) + 18'(raw[i]);
				cal_ring[i][cal_ptr] = raw[i];
				zero_ofs[i] = ADC_BITS'(cal_sum[i] / HIST_DEPTH);
			end
			cal_ptr = (cal_ptr == HIST_DEPTH - 1) ? '0 : cal_ptr + 6'd1;
		end else begin
			for (int i = 0; i < NPHASES; i++)
				if (raw[i] >= zero_ofs[i])
					held_cnt[i] = raw[i] - zero_ofs[i];
			pair_ok = 1'b1;
			case (hall)
				HALL_VW_LO, HALL_VW_HI: pair = BSUM_W'(held_cnt[1]) + BSUM_W'(held_cnt[2]);
				HALL_UV_LO, HALL_UV_HI: pair = BSUM_W'(held_cnt[0]) + BSUM_W'(held_cnt[1]);
				HALL_UW_LO, HALL_UW_HI: pair = BSUM_W'(held_cnt[0]) + BSUM_W'(held_cnt[2]);
				default: begin
					pair    = '0;
					pair_ok = 1'b0;
				end
			endcase
			if (pair_ok)
				bus_ma = 17'((BPROD_W'(pair) * BPROD_W'(gain_q412)) >> GAIN_FRAC);
			for (int i = 0; i < NPHASES; i++)
				lpf_y[i] = lpf_next(lpf_y[i], 32'(held_cnt[i]) * 32'(gain_q412));
			lpf_y[3] = lpf_next(lpf_y[3], 32'(bus_ma) << GAIN_FRAC);
			if (clr)
				for (int i = 0; i < NLANES; i++)
					lpf_y[i] = '0;
		end
		r.u_current   = amps_of(lpf_y[0]);
		r.v_current   = amps_of(lpf_y[1]);
		r.w_current   = amps_of(lpf_y[2]);
		r.bus_current = amps_of(lpf_y[3]);
		r.u_offset    = zero_ofs[0];
		r.v_offset    = zero_ofs[1];
		r.w_offset    = zero_ofs[2];
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [OUT_W-1:0] want,
			input logic [OUT_W-1:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("mismatch in result %0d, %s: expected %0d, got %0d",
					results_seen, name, want, got);
		end
	endfunction

	always @(posedge clk) begin : result_check
		sense_t got;
		sense_t want;
		if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
			got = m_tdata[M_PAYLOAD_W-1:0];
			if (pending_sense.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result %0d: %h", results_seen, got);
			end else begin
				want = pending_sense.pop_front();
				check_field("u_current", want.u_current, got.u_current);
				check_field("v_current", want.v_current, got.v_current);
				check_field("w_current", want.w_current, got.w_current);
				check_field("bus_current", want.bus_current, got.bus_current);
				check_field("u_offset", 20'(want.u_offset), 20'(got.u_offset));
				check_field("v_offset", 20'(want.v_offset), 20'(got.v_offset));
				check_field("w_offset", 20'(want.w_offset), 20'(got.w_offset));
				if (want.bus_current == AMPS_MAX)
					bus_sat_count++;
			end
			results_seen++;
		end
	end

	initial begin : sink_pacing
		int stretch;
		int hold_left;
		stretch   = 0;
		hold_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_req > 0) begin
				hold_left   = rx_hold_req;
				rx_hold_req = 0;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (!rx_idle_on) begin
				m_tready <= 1'b1;
			end else if (stretch > 0) begin
				stretch--;
			end else if ($urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				stretch = $urandom_range(0, 16);
			end else begin
				m_tready <= 1'b1;
				stretch = $urandom_range(0, 40);
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results outstanding",
			cycle_count, pending_sense.size());
		$display("** motor_phase_current_sense_top: FAILED **");
		$finish;
	end

	task automatic send_frame(input logic op, input logic [ADC_BITS-1:0] u,
			input logic [ADC_BITS-1:0] v, input logic [ADC_BITS-1:0] w,
			input logic [HALL_W-1:0] hall, input logic clr);
		if (tx_idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {clr, hall, w, v, u};
		do @(posedge clk); while (s_tready !== 1'b1);
		pending_sense.push_back(predict_sense(op, u, v, w, hall, clr));
		frames_sent++;
		if (op == OP_CALIBRATE)
			cal_frames++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_sense.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		wait_drained();
		repeat (2) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_CURRENT_GAIN)
			gain_q412 = val;
		else
			lpf_coef = val;
		reg_writes++;
	endtask

	function automatic logic [ADC_BITS-1:0] jitter(input int base, input int spread);
		int v;
		v = base + int'($urandom_range(0, 2 * spread)) - spread;
		if (v < 0)
			v = 0;
		else if (v > ADC_MAX)
			v = ADC_MAX;
		return v[ADC_BITS-1:0];
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_reg(input logic [CFG_DATA_W-1:0] typical);
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return typical;
			default: return CFG_DATA_W'($urandom);
		endcase
	endfunction

	task automatic send_noise();
		send_frame(1'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
			3'($urandom), 1'($urandom));
	endtask

	task automatic send_loaded(input int load_u, input int load_v, input int load_w);
		send_frame(OP_MEASURE, jitter(int'(zero_ofs[0]) + load_u, 150),
			jitter(int'(zero_ofs[1]) + load_v, 150), jitter(int'(zero_ofs[2]) + load_w, 150),
			3'($urandom_range(0, 7)), $urandom_range(0, 39) == 0);
	endtask

	task automatic test_directed();
		// filters, bus and offsets all at zero; idle hall states keep the bus at zero
		send_frame(OP_MEASURE, 12'd0, 12'd0, 12'd0, HALL_NONE_LO, 1'b0);
		send_frame(OP_MEASURE, 12'd4095, 12'd4095, 12'd4095, HALL_NONE_HI, 1'b0);
		// clear is ignored while calibrating
		send_frame(OP_CALIBRATE, 12'd4095, 12'd0, 12'd2048, HALL_UV_HI, 1'b1);
		send_frame(OP_CALIBRATE, 12'd4095, 12'd4095, 12'd4095, HALL_UW_LO, 1'b0);
		send_frame(OP_CALIBRATE, 12'd1234, 12'd3000, 12'd4095, HALL_NONE_HI, 1'b0);
		// below the offset: held values stay
		send_frame(OP_MEASURE, 12'd0, 12'd0, 12'd0, HALL_VW_LO, 1'b0);
		// exactly at the offset: held values drop to zero
		send_frame(OP_MEASURE, zero_ofs[0], zero_ofs[1], zero_ofs[2], HALL_UV_LO, 1'b0);
		for (int h = 0; h < 8; h++)
			send_frame(OP_MEASURE, 12'd4095 - 12'(h * 300), 12'd2000 + 12'(h * 200),
				12'd4095, 3'(h), 1'b0);
		send_frame(OP_MEASURE, 12'd4095, 12'd4095, 12'd4095, HALL_UW_HI, 1'b1);
		send_frame(OP_MEASURE, 12'd3000, 12'd1500, 12'd700, HALL_VW_HI, 1'b0);
	endtask

	task automatic test_config_extremes();
		write_reg(REG_CURRENT_GAIN, '0);
		send_frame(OP_MEASURE, 12'd4095, 12'd4095, 12'd4095, HALL_UV_HI, 1'b0);
		send_frame(OP_MEASURE, 12'd2500, 12'd100, 12'd4095, HALL_UW_LO, 1'b0);
		write_reg(REG_CURRENT_GAIN, '1);
		write_reg(REG_FILTER_COEF, '0);
		send_frame(OP_MEASURE, 12'd4095, 12'd4095, 12'd4095, HALL_VW_HI, 1'b0);
		write_reg(REG_FILTER_COEF, '1);
		// full gain, nearly no smoothing: bus output saturates
		send_frame(OP_MEASURE, 12'd4095, 12'd4095, 12'd4095, HALL_UV_HI, 1'b0);
		send_frame(OP_MEASURE, 12'd4095, 12'd4095, 12'd4095, HALL_VW_LO, 1'b0);
		send_frame(OP_MEASURE, 12'd4095, 12'd4095, 12'd4095, HALL_NONE_LO, 1'b1);
		write_reg(REG_CURRENT_GAIN, GAIN_RESET);
		write_reg(REG_FILTER_COEF, COEF_RESET);
	endtask

	task automatic test_random_rounds();
		int base [NPHASES];
		int load [NPHASES];
		int n_cal;
		int n_meas;
		while (frames_sent < 1560) begin
			if ($urandom_range(0, 2) == 0) begin
				write_reg(REG_CURRENT_GAIN, pick_reg(GAIN_RESET));
				write_reg(REG_FILTER_COEF, pick_reg(COEF_RESET));
			end
			for (int i = 0; i < NPHASES; i++) begin
				base[i] = $urandom_range(0, ADC_MAX);
				load[i] = $urandom_range(0, 2500);
			end
			n_cal = $urandom_range(0, 70);
			for (int k = 0; k < n_cal; k++)
				send_frame(OP_CALIBRATE, jitter(base[0], 40), jitter(base[1], 40),
					jitter(base[2], 40), 3'($urandom), 1'($urandom));
			n_meas = $urandom_range(20, 80);
			for (int k = 0; k < n_meas; k++) begin
				if ($urandom_range(0, 9) == 0)
					send_noise();
				else
					send_loaded(load[0], load[1], load[2]);
			end
		end
	endtask

	task automatic test_backpressure();
		rx_hold_req = 400;
		for (int k = 0; k < 30; k++)
			send_loaded(1800, 900, 2400);
		wait_drained();
		for (int k = 0; k < 20; k++)
			send_noise();
	endtask

	task automatic test_full_rate();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		for (int k = 0; k < 100; k++) begin
			if ($urandom_range(0, 4) == 0)
				send_noise();
			else
				send_loaded(1200, 3000, 600);
		end
	endtask

	initial begin : main
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= OP_CALIBRATE;
		cfg_we   <= 1'b0;
		cfg_addr <= REG_CURRENT_GAIN;
		cfg_data <= '0;
		reset_model();
		mismatch_count = 0;
		results_seen   = 0;
		bus_sat_count  = 0;
		frames_sent    = 0;
		cal_frames     = 0;
		reg_writes     = 0;
		rx_hold_req    = 0;
		tx_idle_on     = 1'b1;
		rx_idle_on     = 1'b1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_config_extremes();
		test_random_rounds();
		test_backpressure();
		test_full_rate();

		wait_drained();
		repeat (20) @(posedge clk);
		$display("%0d frames (%0d calibrate, %0d measure), %0d register writes, all hall states",
			frames_sent, cal_frames, frames_sent - cal_frames, reg_writes);
		$display("%0d results checked, %0d with saturated bus current, %0d mismatches",
			results_seen, bus_sat_count, mismatch_count);
		if (mismatch_count == 0 && pending_sense.size() == 0)
			$display("** motor_phase_current_sense_top: PASSED **");
		else
			$display("** motor_phase_current_sense_top: FAILED **");
		$finish;
	end

endmodule
